// ===== sv/sem_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared widths, register indexes and the per-word tag that travels with each
// pixel through the pipeline.
// ----------------------------------------------------------------------------
package sem_pkg;

	// Field widths
	localparam int PIX_W   = 32;
	localparam int INT_W   = 8;
	localparam int COL_W   = 11;
	localparam int ROW_W   = 16;
	localparam int TDATA_W = 64;
	localparam int PAD_W   = TDATA_W - PIX_W - COL_W - ROW_W;

	// Configuration register indexes and widths
	localparam int CFG_W  = 16;
	localparam int IMW_W  = 12;
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [IMW_W-1:0] WIDTH_RESET  = 12'd640;
	localparam logic [ROW_W-1:0] HEIGHT_RESET = 16'd480;

	// Saturation ceiling of the magnitude
	localparam logic [INT_W-1:0] MAG_MAX = 8'hFF;

	// Position and result flags of one pixel word
	typedef struct packed {
		logic             emit;
		logic             last;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
	} sem_tag_t;

endpackage

// ===== sv/sem_line_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel line buffers
// Two synchronous memories: the row above (intensity and alpha) and the row
// two above (intensity). One read and one write per cycle, read data
// registered and held while the read enable is low.
// ----------------------------------------------------------------------------
module sem_line_buf #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [15:0]   rd_near,
	output logic [7:0]    rd_far,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [15:0]   wr_near,
	input  logic [7:0]    wr_far
);

	logic [15:0] near_mem [DEPTH];
	logic [7:0]  far_mem  [DEPTH];

	// Row above: alpha in 15:8, intensity in 7:0
	always_ff @(posedge clk) begin
		if (wr_en) begin
			near_mem[wr_addr] <= wr_near;
		end
		if (rd_en) begin
			rd_near <= near_mem[rd_addr];
		end
	end

	// Row two above: intensity only
	always_ff @(posedge clk) begin
		if (wr_en) begin
			far_mem[wr_addr] <= wr_far;
		end
		if (rd_en) begin
			rd_far <= far_mem[rd_addr];
		end
	end

endmodule

// ===== sv/sem_grad.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel window and gradient
// Holds the 3x3 intensity window and the centre alpha, forms |gx| + |gy|
// saturated to 255 and drives the output word register.
// ----------------------------------------------------------------------------
module sem_grad import sem_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               v_s1,
	input  sem_tag_t           tag_s1,
	input  logic [INT_W-1:0]   int_s1,
	input  logic [15:0]        rd_near,
	input  logic [INT_W-1:0]   rd_far,
	output logic               m_axis_tvalid,
	output logic [TDATA_W-1:0] m_axis_tdata,
	output logic               m_axis_tlast
);

	logic [INT_W-1:0] win_q [3][3];
	logic [INT_W-1:0] prev_alpha_q;

	logic             v_s2;
	sem_tag_t         tag_s2;
	logic [INT_W-1:0] alpha_s2;

	logic [9:0]       gx_pos, gx_neg, gy_pos, gy_neg;
	logic [9:0]       gx_abs, gy_abs;
	logic [10:0]      mag_sum;
	logic [INT_W-1:0] mag;

	// Shift the window and take the new right column; track centre alpha
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
			prev_alpha_q <= '0;
		end else if (adv && v_s1) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2]  <= rd_far;
			win_q[1][2]  <= rd_near[7:0];
			win_q[2][2]  <= int_s1;
			prev_alpha_q <= rd_near[15:8];
		end
	end

	// Stage 2 valid: only interior pixels go on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1 && tag_s1.emit;
		end
	end

	// Stage 2 payload
	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			tag_s2   <= tag_s1;
			alpha_s2 <= prev_alpha_q;
		end
	end

	// Gradients as positive and negative partial sums
	always_comb begin
		gx_pos = {2'b00, win_q[0][0]} + {1'b0, win_q[1][0], 1'b0} + {2'b00, win_q[2][0]};
		gx_neg = {2'b00, win_q[0][2]} + {1'b0, win_q[1][2], 1'b0} + {2'b00, win_q[2][2]};
		gy_pos = {2'b00, win_q[0][0]} + {1'b0, win_q[0][1], 1'b0} + {2'b00, win_q[0][2]};
		gy_neg = {2'b00, win_q[2][0]} + {1'b0, win_q[2][1], 1'b0} + {2'b00, win_q[2][2]};
		gx_abs = (gx_pos >= gx_neg) ? (gx_pos - gx_neg) : (gx_neg - gx_pos);
		gy_abs = (gy_pos >= gy_neg) ? (gy_pos - gy_neg) : (gy_neg - gy_pos);
		mag_sum = {1'b0, gx_abs} + {1'b0, gy_abs};
		mag = (mag_sum > 11'd255) ? MAG_MAX : mag_sum[7:0];
	end

	// Output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (adv) begin
			m_axis_tvalid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			m_axis_tdata <= {{PAD_W{1'b0}}, tag_s2.row, tag_s2.col, alpha_s2, mag, mag, mag};
			m_axis_tlast <= tag_s2.last;
		end
	end

endmodule

// ===== sv/sobel_edge_magnitude_3x3.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel 3x3 edge magnitude, streaming
// Raster-order pixels in, |gx| + |gy| per interior pixel out.
//
//   channel  | dir | payload
//   s_axis   | in  | tdata[31:0] pixel_word
//   m_axis   | out | tdata: out_pixel, out_col, out_row; tlast: frame_end
//   cfg      | in  | cfg_addr 0 image_width, 1 image_height
//
// One pixel per cycle unless the output stalls. An accepted word reads both
// line buffers at its column, writes them back as stage 1 moves on and
// reaches the output via stage 2. A stalled output holds the whole pipeline;
// a waiting result does not block input while the output register is free.
// Line buffers are not cleared after reset; border pixels yield no word.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_3x3 import sem_pkg::*; #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [PIX_W-1:0]   s_axis_tdata,  // pixel_word[31:0]
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [TDATA_W-1:0] m_axis_tdata,  // out_pixel[31:0], out_col[42:32], out_row[58:43]
	output logic               m_axis_tlast,  // frame_end
	input  logic               cfg_we,
	input  logic               cfg_addr,
	input  logic [CFG_W-1:0]   cfg_wdata
);

	localparam int CW = $clog2(MAX_WIDTH);

	logic [IMW_W-1:0] image_width_q;
	logic [ROW_W-1:0] image_height_q;
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;

	logic             adv;
	logic             s_accept;
	logic [CW:0]      width_eff;
	logic [ROW_W-1:0] height_eff;
	logic [CW:0]      col_inc;
	logic [ROW_W:0]   row_inc;
	logic             col_wrap;
	logic             row_wrap;
	logic [CW-1:0]    col_m1;
	sem_tag_t         tag_in;

	logic             v_s1;
	sem_tag_t         tag_s1;
	logic [CW-1:0]    col_s1;
	logic [INT_W-1:0] int_s1;
	logic [INT_W-1:0] alpha_s1;

	logic [15:0]      rd_near;
	logic [INT_W-1:0] rd_far;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_RESET;
			image_height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_wdata[IMW_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_wdata[ROW_W-1:0];
			endcase
		end
	end

	// Pipeline advances whenever the output register is free or drained
	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;
	assign s_accept      = s_axis_tvalid && adv;

	// Clamp image size and work out position flags of the incoming word
	always_comb begin
		if (image_width_q < 12'd3) begin
			width_eff = (CW+1)'(3);
		end else if (image_width_q > MAX_WIDTH) begin
			width_eff = (CW+1)'(MAX_WIDTH);
		end else begin
			width_eff = (CW+1)'(image_width_q);
		end
		height_eff = (image_height_q < 16'd3) ? 16'd3 : image_height_q;
		col_inc    = {1'b0, col_q} + {{CW{1'b0}}, 1'b1};
		row_inc    = {1'b0, row_q} + 17'd1;
		col_wrap   = col_inc >= width_eff;
		row_wrap   = row_inc >= {1'b0, height_eff};
		col_m1     = col_q - CW'(1);
		tag_in.emit = (col_q >= CW'(2)) && (row_q >= 16'd2);
		tag_in.last = (row_inc == {1'b0, height_eff}) && (col_inc == width_eff);
		tag_in.col  = COL_W'(col_m1);
		tag_in.row  = row_q - 16'd1;
	end

	// Column and row counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (s_accept) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_inc[ROW_W-1:0];
			end else begin
				col_q <= col_inc[CW-1:0];
			end
		end
	end

	// Stage 1: line buffer read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			tag_s1   <= tag_in;
			col_s1   <= col_q;
			int_s1   <= s_axis_tdata[7:0];
			alpha_s1 <= s_axis_tdata[31:24];
		end
	end

	// Read at the new column, write back when stage 1 moves on. The same
	// column returns only three or more words later, so no forwarding.
	sem_line_buf #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line_buf (
		.clk     (clk),
		.rd_en   (s_accept),
		.rd_addr (col_q),
		.rd_near (rd_near),
		.rd_far  (rd_far),
		.wr_en   (adv && v_s1),
		.wr_addr (col_s1),
		.wr_near ({alpha_s1, int_s1}),
		.wr_far  (rd_near[7:0])
	);

	sem_grad u_grad (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.v_s1          (v_s1),
		.tag_s1        (tag_s1),
		.int_s1        (int_s1),
		.rd_near       (rd_near),
		.rd_far        (rd_far),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ===== sv/sem_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module sem_check import sem_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               s_axis_tready,
	input logic               m_axis_tvalid,
	input logic               m_axis_tready,
	input logic [TDATA_W-1:0] m_axis_tdata,
	input logic               m_axis_tlast
);

	// Hold a stalled output word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output word changed while stalled");

	// Input is open whenever the output register is empty or draining
	a_in_open: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid || m_axis_tready |-> s_axis_tready)
		else $error("input blocked with free output register");

	// Magnitude replicated into all three color bytes, padding zero
	a_replicate: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[23:16] == m_axis_tdata[15:8] &&
			m_axis_tdata[15:8] == m_axis_tdata[7:0] && m_axis_tdata[63:59] == 5'd0)
		else $error("bad magnitude replication or padding");

	// No result on the top row, and no row index of all ones
	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[58:43] != 16'd0 && m_axis_tdata[58:43] != 16'hFFFF)
		else $error("result row on image border");

endmodule

bind sobel_edge_magnitude_3x3 sem_check u_sem_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

// ===== sim/tb_sobel_edge_magnitude_3x3.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel 3x3 edge magnitude testbench
// Streams raster images through the block and predicts every interior word:
// gradient sum with saturation, centre alpha, position and end of frame.
// Runs short fixed images first, then a long row at the clamped width and the
// tallest height, then random images under four idling mixes. Changes the
// geometry in the middle of some images once the pipeline has drained.
// ----------------------------------------------------------------------------
module tb_sobel_edge_magnitude_3x3 import sem_pkg::*;;

	localparam int LINE_DEPTH = 2048;

	// One predicted output word
	typedef struct {
		logic [PIX_W-1:0] pixel;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             frame_end;
	} edge_word_t;

	// Sobel predictor and queue of words still to arrive
	class edge_scoreboard;
		logic [IMW_W-1:0] width_reg = WIDTH_RESET;
		logic [ROW_W-1:0] height_reg = HEIGHT_RESET;
		logic [15:0] above_line [LINE_DEPTH];
		logic [7:0] two_above_line [LINE_DEPTH];
		logic [7:0] win [3][3];
		logic [15:0] alpha_pipe = '0;
		int col_cnt = 0;
		int row_cnt = 0;
		int errors = 0;
		edge_word_t edges_due[$];

		function int width_eff();
			int w;
			w = width_reg;
			if (w < 3) w = 3;
			if (w > LINE_DEPTH) w = LINE_DEPTH;
			return w;
		endfunction

		function int height_eff();
			return (height_reg < 3) ? 3 : int'(height_reg);
		endfunction

		function bit at_frame_start();
			return col_cnt == 0 && row_cnt == 0;
		endfunction

		function int pending();
			return edges_due.size();
		endfunction

		function void write_reg(logic addr, logic [CFG_W-1:0] data);
			if (addr == REG_IMAGE_WIDTH) begin
				width_reg = data[IMW_W-1:0];
			end else begin
				height_reg = data;
			end
		endfunction

		// Advance the window by one accepted pixel and queue its word, if any
		function void note_pixel(logic [PIX_W-1:0] pix);
			int w, h, gx, gy, mag;
			logic [7:0] far_int, near_int, near_alpha, centre_alpha, m;
			edge_word_t want;
			w = width_eff();
			h = height_eff();
			far_int = two_above_line[col_cnt];
			near_int = above_line[col_cnt][7:0];
			near_alpha = above_line[col_cnt][15:8];
			for (int k = 0; k < 3; k++) begin
				win[k][0] = win[k][1];
				win[k][1] = win[k][2];
			end
			win[0][2] = far_int;
			win[1][2] = near_int;
			win[2][2] = pix[7:0];
			centre_alpha = alpha_pipe[7:0];
			alpha_pipe = {alpha_pipe[7:0], near_alpha};
			two_above_line[col_cnt] = near_int;
			above_line[col_cnt] = {pix[31:24], pix[7:0]};

			if (col_cnt >= 2 && row_cnt >= 2) begin
				gx = int'(win[0][0]) + 2 * int'(win[1][0]) + int'(win[2][0])
					- int'(win[0][2]) - 2 * int'(win[1][2]) - int'(win[2][2]);
				gy = int'(win[0][0]) + 2 * int'(win[0][1]) + int'(win[0][2])
					- int'(win[2][0]) - 2 * int'(win[2][1]) - int'(win[2][2]);
				mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
				m = (mag > 255) ? 8'hFF : 8'(mag);
				want.pixel = {centre_alpha, m, m, m};
				want.col = COL_W'(col_cnt - 1);
				want.row = ROW_W'(row_cnt - 1);
				want.frame_end = (row_cnt + 1 == h) && (col_cnt + 1 == w);
				edges_due.push_back(want);
			end

			// Step the raster position
			if (col_cnt + 1 >= w) begin
				col_cnt = 0;
				row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
			end else begin
				col_cnt = col_cnt + 1;
			end
		endfunction

		function void report(string field, logic [PIX_W-1:0] want, logic [PIX_W-1:0] got);
			errors++;
			$display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
		endfunction

		// Compare one output word with the oldest prediction
		function void check_word(logic [TDATA_W-1:0] data, logic last);
			edge_word_t want;
			if (edges_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected word: expected none, actual %h last %b",
					$time, data, last);
				return;
			end
			want = edges_due.pop_front();
			if (data[PIX_W-1:0] !== want.pixel)
				report("out_pixel", want.pixel, data[PIX_W-1:0]);
			if (data[PIX_W +: COL_W] !== want.col)
				report("out_col", PIX_W'(want.col), PIX_W'(data[PIX_W +: COL_W]));
			if (data[PIX_W+COL_W +: ROW_W] !== want.row)
				report("out_row", PIX_W'(want.row), PIX_W'(data[PIX_W+COL_W +: ROW_W]));
			if (last !== want.frame_end)
				report("frame_end", PIX_W'(want.frame_end), PIX_W'(last));
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [PIX_W-1:0]   s_axis_tdata = '0;    // pixel_word[31:0]
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [TDATA_W-1:0] m_axis_tdata;         // out_pixel[31:0], out_col[42:32], out_row[58:43]
	logic               m_axis_tlast;         // frame_end
	logic               cfg_we = 1'b0;
	logic               cfg_addr = 1'b0;
	logic [CFG_W-1:0]   cfg_wdata = '0;

	int idle_pct = 0;
	int stall_pct = 0;

	edge_scoreboard sb = new;

	sobel_edge_magnitude_3x3 u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Stall the output at the current rate
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	// Check every accepted output word
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_word(m_axis_tdata, m_axis_tlast);
	end

	// Offer one pixel word, optionally after waiting for the pipeline to empty
	task automatic push_pixel(input logic [PIX_W-1:0] pix, input bit pause);
		if (pause) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
			while (sb.pending() != 0) @(posedge clk);
		end
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= pix;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_pixel(pix);
	endtask

	// Hold input until all words are out, then let the pipeline settle
	task automatic drain_idle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Write both geometry registers back to back
	task automatic set_geometry(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
		cfg_we <= 1'b1;
		cfg_addr <= REG_IMAGE_WIDTH;
		cfg_wdata <= w;
		@(posedge clk);
		sb.write_reg(REG_IMAGE_WIDTH, w);
		cfg_addr <= REG_IMAGE_HEIGHT;
		cfg_wdata <= h;
		@(posedge clk);
		sb.write_reg(REG_IMAGE_HEIGHT, h);
		cfg_we <= 1'b0;
	endtask

	// Width value with junk above the 12 register bits
	function automatic logic [CFG_W-1:0] width_word(int w);
		return {4'($urandom_range(15)), IMW_W'(w)};
	endfunction

	// Pixel of a given texture: random, smooth around base, or hard black and white
	function automatic logic [PIX_W-1:0] make_pixel(int style, logic [7:0] base);
		logic [PIX_W-1:0] pix;
		pix = $urandom;
		case (style)
			0: ;
			1: pix[7:0] = base + 8'($urandom_range(8));
			default: pix[7:0] = $urandom_range(1) ? 8'hFF : 8'h00;
		endcase
		return pix;
	endfunction

	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int sent, n_img, cut_at, k, style, w_raw, h_raw;
		logic [7:0] base;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fixed 3x3 images: saturated gx, flat zero, saturated gy with clamped geometry
		drain_idle();
		set_geometry(width_word(3), 16'd3);
		for (int i = 0; i < 9; i++)
			push_pixel({(i == 4) ? 8'hFF : 8'h5A, 16'h3C96,
				(i % 3 == 0) ? 8'hFF : (i % 3 == 1) ? 8'h80 : 8'h00}, 1'b0);
		for (int i = 0; i < 9; i++)
			push_pixel(32'h0, 1'b0);
		drain_idle();
		set_geometry(16'hF000, 16'd1);
		for (int i = 0; i < 9; i++)
			push_pixel((i < 3) ? 32'hFFFF_FFFF : (i < 6) ? 32'h7F00_0080 : 32'h00FF_FF00, 1'b0);

		// Long row at the clamped width, then shrink the width to end the image
		idle_pct = 9;
		stall_pct = 9;
		drain_idle();
		set_geometry(width_word(4095), 16'd3);
		for (int i = 0; i < 200; i++)
			push_pixel($urandom, 1'b0);
		drain_idle();
		set_geometry(width_word(4), 16'd3);
		while (!sb.at_frame_start()) push_pixel($urandom, 1'b0);

		// Tallest image, cut short by lowering the height
		drain_idle();
		set_geometry(width_word(3), 16'hFFFF);
		for (int i = 0; i < 12; i++)
			push_pixel($urandom, 1'b0);
		drain_idle();
		set_geometry(width_word(3), 16'd2);
		while (!sb.at_frame_start()) push_pixel($urandom, 1'b0);

		// Random images under each idling mix
		for (int p = 0; p < 4; p++) begin
			idle_pct = (p == 1 || p == 3) ? ((p == 1) ? 62 : 9) : 0;
			stall_pct = (p == 2) ? 62 : (p == 3) ? 9 : 0;
			sent = 0;
			while (sent < 280) begin
				w_raw = ($urandom_range(9) == 0) ? $urandom_range(2) :
					($urandom_range(5) == 0) ? $urandom_range(17, 64) : $urandom_range(3, 16);
				h_raw = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 6);
				drain_idle();
				set_geometry(width_word(w_raw), 16'(h_raw));
				n_img = $urandom_range(1, 3);
				for (int i = 0; i < n_img; i++) begin
					cut_at = (i == n_img - 1 && $urandom_range(5) == 0) ?
						$urandom_range(1, sb.width_eff() * sb.height_eff() - 1) : -1;
					style = $urandom_range(2);
					base = 8'($urandom);
					k = 0;
					do begin
						// Shrink width, change height mid-image once idle
						if (k == cut_at) begin
							drain_idle();
							set_geometry(width_word($urandom_range(sb.width_eff())),
								16'($urandom_range(sb.height_eff() + 2)));
						end
						push_pixel(make_pixel(style, base), $urandom_range(199) == 0);
						k++;
						sent++;
					end while (!sb.at_frame_start());
				end
			end
		end

		// Wait out the remaining words
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
